FILE: rtl/core/fcull_pkg.sv
// Shared constants and types for the frustum box cull block.
`timescale 1ns / 1ps

package fcull_pkg;

	// Defaults for the top-level parameters.
	localparam int PLANE_COUNT_DEF = 6;
	localparam int COORD_BITS_DEF  = 16;

	// Number of plane registers on the configuration port.
	localparam int PLANE_REGS = 6;

	// Plane register layout: four signed 16-bit fields.
	localparam int PLANE_W      = 64;
	localparam int PFIELD_W     = 16;
	localparam int NX_LSB       = 48;
	localparam int NY_LSB       = 32;
	localparam int NZ_LSB       = 16;
	localparam int OFS_LSB      = 0;
	localparam int OFFSET_SHIFT = 14;

	// Configuration port geometry: 64-bit registers at byte address 8*i.
	localparam int APB_DATA_W = 64;
	localparam int APB_ADDR_W = 6;
	localparam int REG_IDX_W  = 3;
	localparam int REG_IDX_LSB = 3;

	// Register indexes.
	typedef enum logic [REG_IDX_W-1:0] {
		REG_PLANE_ONE   = 3'd0,
		REG_PLANE_TWO   = 3'd1,
		REG_PLANE_THREE = 3'd2,
		REG_PLANE_FOUR  = 3'd3,
		REG_PLANE_FIVE  = 3'd4,
		REG_PLANE_SIX   = 3'd5
	} reg_idx_t;

	// Load enables for the three lane pipeline stages.
	typedef struct packed {
		logic load_s1;
		logic load_s2;
		logic load_s3;
	} pipe_ctl_t;

endpackage

FILE: rtl/core/fcull_regs.sv
// Plane registers behind the configuration port.
`timescale 1ns / 1ps

module fcull_regs (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [fcull_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [fcull_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [fcull_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                  pready,
	output logic [fcull_pkg::PLANE_W-1:0]         plane_q [fcull_pkg::PLANE_REGS]
);

	logic [fcull_pkg::REG_IDX_W-1:0] idx;
	logic                            idx_ok;
	logic                            wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[fcull_pkg::REG_IDX_LSB +: fcull_pkg::REG_IDX_W];
	assign idx_ok = (idx <= fcull_pkg::REG_PLANE_SIX);
	assign wr_en  = psel && penable && pwrite;

	// Write the addressed plane; writes beyond the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fcull_pkg::PLANE_REGS; i++) begin
				plane_q[i] <= '0;
			end
		end else if (wr_en && idx_ok) begin
			plane_q[idx] <= pwdata;
		end
	end

	// Read back the addressed plane, zero outside the register map.
	always_comb begin
		if (idx_ok) begin
			prdata = plane_q[idx];
		end else begin
			prdata = '0;
		end
	end

endmodule

FILE: rtl/core/fcull_lane.sv
// One plane lane: positive vertex select, products, and distance sign.
`timescale 1ns / 1ps

module fcull_lane #(
	parameter int COORD_BITS = fcull_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  fcull_pkg::pipe_ctl_t                ctl,
	input  logic [fcull_pkg::PLANE_W-1:0]       plane,
	input  logic signed [COORD_BITS-1:0]        min_x,
	input  logic signed [COORD_BITS-1:0]        min_y,
	input  logic signed [COORD_BITS-1:0]        min_z,
	input  logic signed [COORD_BITS-1:0]        max_x,
	input  logic signed [COORD_BITS-1:0]        max_y,
	input  logic signed [COORD_BITS-1:0]        max_z,
	output logic                                neg_s3
);

	localparam int PROD_W = fcull_pkg::PFIELD_W + COORD_BITS;
	localparam int OFS_W  = fcull_pkg::PFIELD_W + fcull_pkg::OFFSET_SHIFT;
	localparam int SUM_W  = ((PROD_W > OFS_W) ? PROD_W : OFS_W) + 2;

	logic signed [fcull_pkg::PFIELD_W-1:0] nx, ny, nz, ofs;
	logic signed [COORD_BITS-1:0]          vx_s1, vy_s1, vz_s1;
	logic signed [PROD_W-1:0]              px_s2, py_s2, pz_s2;
	logic signed [SUM_W-1:0]               ofs_term;
	logic signed [SUM_W-1:0]               dist_sum;

	assign nx  = plane[fcull_pkg::NX_LSB +: fcull_pkg::PFIELD_W];
	assign ny  = plane[fcull_pkg::NY_LSB +: fcull_pkg::PFIELD_W];
	assign nz  = plane[fcull_pkg::NZ_LSB +: fcull_pkg::PFIELD_W];
	assign ofs = plane[fcull_pkg::OFS_LSB +: fcull_pkg::PFIELD_W];

	// Stage 1: per axis, min where the normal is negative, else max.
	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			vx_s1 <= nx[fcull_pkg::PFIELD_W-1] ? min_x : max_x;
			vy_s1 <= ny[fcull_pkg::PFIELD_W-1] ? min_y : max_y;
			vz_s1 <= nz[fcull_pkg::PFIELD_W-1] ? min_z : max_z;
		end
	end

	// Stage 2: one product per axis.
	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			px_s2 <= PROD_W'(nx) * PROD_W'(vx_s1);
			py_s2 <= PROD_W'(ny) * PROD_W'(vy_s1);
			pz_s2 <= PROD_W'(nz) * PROD_W'(vz_s1);
		end
	end

	// Stage 3: distance sign; user to hold planes still with items in flight, unchecked.
	assign ofs_term = SUM_W'(ofs) <<< fcull_pkg::OFFSET_SHIFT;
	assign dist_sum = SUM_W'(px_s2) + SUM_W'(py_s2) + SUM_W'(pz_s2) + ofs_term;

	always_ff @(posedge clk) begin
		if (ctl.load_s3) begin
			neg_s3 <= dist_sum[SUM_W-1];
		end
	end

endmodule

FILE: rtl/core/frustum_box_cull.sv
// A box moves through stages 1 to 3 and the stage 4 output register to m_tvalid.
// Throughput: one box per cycle unless stalled; three multipliers per lane, in one stage.
// Stalls on the output side back up stage by stage; bubbles are squeezed out.
// Reset clears all plane registers to zero (planes never cull) and every stage valid bit.
// Configuration writes are meant to land only while the pipeline is empty.
`timescale 1ns / 1ps

module frustum_box_cull #(
	parameter int PLANE_COUNT = fcull_pkg::PLANE_COUNT_DEF,
	parameter int COORD_BITS  = fcull_pkg::COORD_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Box request: min_x, min_y, min_z, max_x, max_y, max_z from bit 0 up, zero padded.
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((6*COORD_BITS+7)/8)*8-1:0]     s_tdata,
	// Result: visible in bit 0, upper bits zero.
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [7:0]                            m_tdata,
	// Configuration port.
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [fcull_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [fcull_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [fcull_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                  pready
);

	logic [fcull_pkg::PLANE_W-1:0] plane_q [fcull_pkg::PLANE_REGS];
	logic [fcull_pkg::PLANE_W-1:0] plane   [PLANE_COUNT];
	logic [PLANE_COUNT-1:0]        neg_s3;

	logic signed [COORD_BITS-1:0] min_x, min_y, min_z, max_x, max_y, max_z;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic ready_s1, ready_s2, ready_s3, ready_s4;
	logic inv_s1, inv_s2, inv_s3;
	logic vis_s4;
	fcull_pkg::pipe_ctl_t ctl;

	fcull_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.plane_q (plane_q)
	);

	// Unpack the box corners.
	assign min_x = s_tdata[0*COORD_BITS +: COORD_BITS];
	assign min_y = s_tdata[1*COORD_BITS +: COORD_BITS];
	assign min_z = s_tdata[2*COORD_BITS +: COORD_BITS];
	assign max_x = s_tdata[3*COORD_BITS +: COORD_BITS];
	assign max_y = s_tdata[4*COORD_BITS +: COORD_BITS];
	assign max_z = s_tdata[5*COORD_BITS +: COORD_BITS];

	// Each stage takes new data when it is empty or its successor moves on.
	assign ready_s4 = !valid_s4 || m_tready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign s_tready = ready_s1;

	assign ctl.load_s1 = ready_s1;
	assign ctl.load_s2 = ready_s2;
	assign ctl.load_s3 = ready_s3;

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= s_tvalid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	// Inverted-box flag rides alongside the plane lanes.
	always_ff @(posedge clk) begin
		if (ready_s1) inv_s1 <= (min_x > max_x) || (min_y > max_y) || (min_z > max_z);
		if (ready_s2) inv_s2 <= inv_s1;
		if (ready_s3) inv_s3 <= inv_s2;
	end

	// Plane lanes; planes without a register stay zero and never cull.
	for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_lane
		if (i < fcull_pkg::PLANE_REGS) begin : g_reg
			assign plane[i] = plane_q[i];
		end else begin : g_zero
			assign plane[i] = '0;
		end

		fcull_lane #(
			.COORD_BITS (COORD_BITS)
		) u_lane (
			.clk    (clk),
			.ctl    (ctl),
			.plane  (plane[i]),
			.min_x  (min_x),
			.min_y  (min_y),
			.min_z  (min_z),
			.max_x  (max_x),
			.max_y  (max_y),
			.max_z  (max_z),
			.neg_s3 (neg_s3[i])
		);
	end

	// Stage 4: output register; visible only if the box is not inverted and no plane culls.
	always_ff @(posedge clk) begin
		if (ready_s4) vis_s4 <= !inv_s3 && !(|neg_s3);
	end

	assign m_tvalid = valid_s4;
	assign m_tdata  = {7'd0, vis_s4};

endmodule
